FILE: sv/bft_pkg.sv
// Shared types and constants for the Bloom filter test-or-set block.
`timescale 1ns / 1ps
package bft_pkg;
   localparam int MAX_FUNCS      = 9;
   localparam int MAX_KEY_WINDOW = 64;
   localparam int STORE_BITS     = 1048576;
   localparam int COEF_SLOTS     = MAX_FUNCS * MAX_KEY_WINDOW;
   localparam int COEF_AW        = $clog2(COEF_SLOTS);
   localparam int STORE_WORDS    = STORE_BITS / 32;
   localparam int STORE_AW       = $clog2(STORE_WORDS);
   localparam int BIT_IDX_W      = $clog2(STORE_BITS);
   localparam int FUNC_W         = $clog2(MAX_FUNCS);
   localparam int POS_W          = $clog2(MAX_KEY_WINDOW);

   // Request kinds
   localparam logic REQ_COEF = 1'b0;
   localparam logic REQ_KEY  = 1'b1;

   // Register indexes
   localparam logic [1:0] CSR_NUM_FUNCS  = 2'd0;
   localparam logic [1:0] CSR_KEY_WINDOW = 2'd1;
   localparam logic [1:0] CSR_MODULUS    = 2'd2;

   // Effective (clamped) configuration
   typedef struct packed {
      logic [3:0]  nf;
      logic [6:0]  w;
      logic [20:0] m;
   } cfg_type;

   // One queued request
   typedef struct packed {
      logic        is_key;
      logic [9:0]  coef_index;
      logic [31:0] coef_value;
      logic [7:0]  key_byte;
      logic        last;
      logic        do_set;
   } item_type;

   // Back-end status toward the top level
   typedef struct packed {
      logic clearing;
      logic loading;
   } eng_status_type;
endpackage

FILE: sv/bft_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bft_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 576
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

FILE: sv/bft_front.sv
// Front end: accepts requests, drops out-of-range loads, queues the rest.
`timescale 1ns / 1ps
module bft_front import bft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        hold,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_type,
   input  logic [9:0]  req_coef_index,
   input  logic [31:0] req_coef_value,
   input  logic [7:0]  req_key_byte,
   input  logic        req_last_byte,
   input  logic        req_do_set,
   output logic        item_valid,
   output item_type    item,
   input  logic        item_take
);
   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept, keep;

   assign req_full   = (count_ff == 2'd2) || hold;
   assign accept     = req_push && !req_full;
   // a load to a slot past the table does nothing
   assign keep       = (req_type == REQ_KEY) || (req_coef_index < 10'(COEF_SLOTS));
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept && keep) begin
         wr_ptr_in = !wr_ptr_ff;
         count_in  = count_in + 2'd1;
      end
      if (item_take && item_valid) begin
         rd_ptr_in = !rd_ptr_ff;
         count_in  = count_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (accept && keep) begin
         entry_ff[wr_ptr_ff] <= '{is_key: req_type == REQ_KEY, coef_index: req_coef_index,
                                  coef_value: req_coef_value, key_byte: req_key_byte,
                                  last: req_last_byte, do_set: req_do_set};
      end
   end
endmodule

FILE: sv/bft_divider.sv
// Restoring remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps
module bft_divider import bft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [20:0] divisor,
   output logic        done,
   output logic [20:0] remainder
);
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] q_ff, q_in;
   logic [20:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [21:0] trial;

   assign trial     = {rem_ff, q_ff[31]};
   assign done      = done_ff;
   assign remainder = rem_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         q_in    = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         q_in = {q_ff[30:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) rem_in = 21'(trial - {1'b0, dvs_ff});
         else rem_in = trial[20:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end
endmodule

FILE: sv/bft_engine.sv
// Back end: hashing, index reduction, bit probing and the result register.
`timescale 1ns / 1ps
module bft_engine import bft_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           item_valid,
   input  item_type       item,
   output logic           item_take,
   output eng_status_type status,
   output logic           rsp_empty,
   input  logic           rsp_pop,
   output logic [3:0]     rsp_missing_bits,
   output logic [20:0]    rsp_bits_set,
   output logic [31:0]    rsp_unique_count
);
   typedef enum logic [9:0] {
      ST_CLEAR = 10'b0000000001,
      ST_IDLE  = 10'b0000000010,
      ST_POS   = 10'b0000000100,
      ST_CRD   = 10'b0000001000,
      ST_CMUL  = 10'b0000010000,
      ST_CACC  = 10'b0000100000,
      ST_MOD   = 10'b0001000000,
      ST_PRD   = 10'b0010000000,
      ST_PCHK  = 10'b0100000000,
      ST_DONE  = 10'b1000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [STORE_AW:0]    clr_ff, clr_in;
   logic [31:0]          acc_ff [MAX_FUNCS];
   logic [31:0]          cnt_ff, cnt_in;
   logic [FUNC_W-1:0]    f_ff, f_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [BIT_IDX_W-1:0] idx_ff, idx_in;
   logic [31:0]          prod_ff;
   logic [7:0]           byte_ff;
   logic                 last_ff, set_ff;
   logic [3:0]           miss_ff, miss_in;
   logic [20:0]          total_ff, total_in;
   logic [31:0]          uniq_ff, uniq_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 load;
   logic                 div_start, div_done;
   logic [31:0]          div_dividend;
   logic [20:0]          div_divisor, div_rem;
   logic                 coef_we;
   logic [COEF_AW-1:0]   coef_raddr;
   logic [31:0]          coef_rdata;
   logic                 st_we;
   logic [STORE_AW-1:0]  st_waddr;
   logic [31:0]          st_wdata, st_rdata, st_mask;
   logic                 bit_hit, take_key, take_coef;

   bft_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .remainder(div_rem)
   );

   bft_ram #(.WIDTH(32), .DEPTH(COEF_SLOTS)) u_coef (
      .clock(clock), .we(coef_we), .waddr(item.coef_index[COEF_AW-1:0]),
      .wdata(item.coef_value), .raddr(coef_raddr), .rdata(coef_rdata)
   );

   bft_ram #(.WIDTH(32), .DEPTH(STORE_WORDS)) u_store (
      .clock(clock), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
      .raddr(idx_ff[BIT_IDX_W-1:5]), .rdata(st_rdata)
   );

   assign take_coef  = (state_ff == ST_IDLE) && item_valid && !item.is_key;
   assign take_key   = (state_ff == ST_IDLE) && item_valid && item.is_key;
   assign item_take  = take_coef || take_key;
   assign coef_we    = take_coef;
   // slot f * w + pos never passes the table
   assign coef_raddr = COEF_AW'(COEF_AW'(f_ff) * COEF_AW'(cfg.w) + COEF_AW'(pos_ff));

   assign st_mask  = 32'd1 << idx_ff[4:0];
   assign bit_hit  = (st_rdata & st_mask) != 32'd0;
   assign st_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_PCHK) && !bit_hit && set_ff);
   assign st_waddr = (state_ff == ST_CLEAR) ? clr_ff[STORE_AW-1:0] : idx_ff[BIT_IDX_W-1:5];
   assign st_wdata = (state_ff == ST_CLEAR) ? 32'd0 : (st_rdata | st_mask);

   assign load   = (state_ff == ST_DONE) && (!out_valid_ff || rsp_pop);
   assign status = '{clearing: state_ff == ST_CLEAR, loading: load};

   // divider operand selection
   always_comb begin
      div_start    = 1'b0;
      div_dividend = cnt_ff + 32'd1;
      div_divisor  = 21'(cfg.w);
      if (take_key) div_start = 1'b1;
      if ((state_ff == ST_CACC) && (f_ff == FUNC_W'(MAX_FUNCS - 1)) && last_ff) begin
         div_start    = 1'b1;
         div_dividend = acc_ff[0];
         div_divisor  = cfg.m;
      end
      if ((state_ff == ST_PCHK) && (4'(f_ff) + 4'd1 < cfg.nf)) begin
         div_start    = 1'b1;
         div_dividend = acc_ff[f_ff + FUNC_W'(1)];
         div_divisor  = cfg.m;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cnt_in       = cnt_ff;
      f_in         = f_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      miss_in      = miss_ff;
      total_in     = total_ff;
      uniq_in      = uniq_ff;
      out_valid_in = out_valid_ff;
      if (rsp_pop && out_valid_ff) out_valid_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + (STORE_AW + 1)'(1);
            if (clr_ff == (STORE_AW + 1)'(STORE_WORDS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (take_key) begin
               cnt_in   = cnt_ff + 32'd1;
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            if (div_done) begin
               pos_in   = div_rem[POS_W-1:0];
               f_in     = '0;
               state_in = ST_CRD;
            end
         end
         ST_CRD:  state_in = ST_CMUL;
         ST_CMUL: state_in = ST_CACC;
         ST_CACC: begin
            if (f_ff == FUNC_W'(MAX_FUNCS - 1)) begin
               f_in     = '0;
               miss_in  = 4'd0;
               state_in = last_ff ? ST_MOD : ST_IDLE;
            end else begin
               f_in     = f_ff + FUNC_W'(1);
               state_in = ST_CRD;
            end
         end
         ST_MOD: begin
            if (div_done) begin
               idx_in   = div_rem[BIT_IDX_W-1:0];
               state_in = ST_PRD;
            end
         end
         ST_PRD: state_in = ST_PCHK;
         ST_PCHK: begin
            if (!bit_hit) miss_in = miss_ff + 4'd1;
            if (4'(f_ff) + 4'd1 < cfg.nf) begin
               f_in     = f_ff + FUNC_W'(1);
               state_in = ST_MOD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               if (set_ff && (miss_ff != 4'd0)) begin
                  total_in = total_ff + 21'(miss_ff);
                  uniq_in  = uniq_ff + 32'd1;
               end
               cnt_in       = 32'd0;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= 32'd0;
         total_ff     <= 21'd0;
         uniq_ff      <= 32'd0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_FUNCS; i++) acc_ff[i] <= 32'd0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         uniq_ff      <= uniq_in;
         out_valid_ff <= out_valid_in;
         // accumulate, then zero after the key completes
         if (state_ff == ST_CACC) acc_ff[f_ff] <= acc_ff[f_ff] + prod_ff;
         if (load) for (int i = 0; i < MAX_FUNCS; i++) acc_ff[i] <= 32'd0;
      end
      f_ff    <= f_in;
      pos_ff  <= pos_in;
      idx_ff  <= idx_in;
      miss_ff <= miss_in;
      prod_ff <= 32'(byte_ff) * coef_rdata;
      if (take_key) begin
         byte_ff <= item.key_byte;
         last_ff <= item.last;
         set_ff  <= item.do_set;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_missing_bits <= miss_ff;
         rsp_bits_set     <= total_in;
         rsp_unique_count <= uniq_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
endmodule

FILE: sv/bloom_filter_test_or_set.sv
// Top level of the Bloom filter test-or-set block.
//
// Requests enter through a queue port (req_push / req_full): a coefficient
// load writes one 32-bit hash coefficient, a key byte updates the nine hash
// accumulators. The request marked last_byte probes num_funcs bits of a
// 1M-bit store and produces one result on the rsp_ queue port (rsp_empty /
// rsp_pop), holding the count of clear bits found and the running counters.
// Registers are written through csr_valid / csr_ready (always ready).
// A two-entry request queue decouples the front from the engine.
// A coefficient load is written into the table when the engine takes it;
// a key byte starts the remainder unit for its byte position, then does a
// coefficient read, multiply and accumulate for each of the nine functions.
// The last byte then runs, per probed function, the remainder unit plus a
// read/modify/write of the store word, and finally loads the result register.
// After reset the store is cleared one 32-bit word a cycle; req_full stays
// high meanwhile. When the result register is still occupied the engine
// waits, and requests keep queueing until req_full rises.
`timescale 1ns / 1ps
module bloom_filter_test_or_set import bft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_type,
   input  logic [9:0]  req_coef_index,
   input  logic [31:0] req_coef_value,
   input  logic [7:0]  req_key_byte,
   input  logic        req_last_byte,
   input  logic        req_do_set,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_missing_bits,
   output logic [20:0] rsp_bits_set,
   output logic [31:0] rsp_unique_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [20:0] csr_wdata
);
   logic [3:0]     num_funcs_ff;
   logic [6:0]     key_window_ff;
   logic [20:0]    modulus_ff;
   cfg_type        cfg;
   logic [7:0]     w_even;
   item_type       item;
   logic           item_valid, item_take;
   eng_status_type status;

   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         num_funcs_ff  <= 4'd4;
         key_window_ff <= 7'd16;
         modulus_ff    <= 21'd1048573;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_FUNCS:  num_funcs_ff  <= csr_wdata[3:0];
            CSR_KEY_WINDOW: key_window_ff <= csr_wdata[6:0];
            CSR_MODULUS:    modulus_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp to usable values
   assign w_even = {1'b0, key_window_ff} + {7'd0, key_window_ff[0]};
   always_comb begin
      cfg.nf = num_funcs_ff;
      if (num_funcs_ff == 4'd0) cfg.nf = 4'd1;
      else if (num_funcs_ff > 4'(MAX_FUNCS)) cfg.nf = 4'(MAX_FUNCS);
      cfg.w = w_even[6:0];
      if (w_even < 8'd2) cfg.w = 7'd2;
      else if (w_even > 8'(MAX_KEY_WINDOW)) cfg.w = 7'(MAX_KEY_WINDOW);
      cfg.m = modulus_ff;
      if (modulus_ff == 21'd0) cfg.m = 21'd1;
      else if (modulus_ff > 21'(STORE_BITS)) cfg.m = 21'(STORE_BITS);
   end

   bft_front u_front (
      .clock(clock), .reset(reset), .hold(status.clearing),
      .req_push(req_push), .req_full(req_full), .req_type(req_type),
      .req_coef_index(req_coef_index), .req_coef_value(req_coef_value),
      .req_key_byte(req_key_byte), .req_last_byte(req_last_byte),
      .req_do_set(req_do_set), .item_valid(item_valid), .item(item),
      .item_take(item_take)
   );

   bft_engine u_engine (
      .clock(clock), .reset(reset), .cfg(cfg), .item_valid(item_valid),
      .item(item), .item_take(item_take), .status(status),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_missing_bits(rsp_missing_bits), .rsp_bits_set(rsp_bits_set),
      .rsp_unique_count(rsp_unique_count)
   );

   // no request enters while the store is being cleared
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> req_full) else $error("request port open during clear");

   // a popped result with nothing new behind it leaves the port empty
   a_pop_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !status.loading) |=> rsp_empty)
      else $error("result not released after pop");

   // a fresh result never reports more clear bits than functions probed
   a_missing_bound: assert property (@(posedge clock) disable iff (reset)
      status.loading |=> (rsp_missing_bits <= $past(cfg.nf)))
      else $error("missing count exceeds function count");
endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the Bloom filter test-or-set block.
`timescale 1ns / 1ps
module testbench;
   import bft_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 100000;
   localparam int SETTLE_CYCLES = 600;
   localparam int MAX_KEY_LEN = 40;

   typedef struct {
      bit [3:0]  missing_bits;
      bit [20:0] bits_set;
      bit [31:0] unique_count;
   } bloom_rsp_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_type = REQ_COEF;
   logic [9:0]  req_coef_index = '0;
   logic [31:0] req_coef_value = '0;
   logic [7:0]  req_key_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        req_do_set = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [3:0]  rsp_missing_bits;
   logic [20:0] rsp_bits_set;
   logic [31:0] rsp_unique_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_NUM_FUNCS;
   logic [20:0] csr_wdata = '0;

   bloom_filter_test_or_set dut (.*);

   // Shadow of the block's state and registers
   bit            shadow_store [STORE_BITS];
   bit [31:0]     shadow_coef [COEF_SLOTS];
   bit [31:0]     shadow_acc [MAX_FUNCS];
   bit [31:0]     shadow_byte_count;
   int unsigned   shadow_bits_total;
   bit [31:0]     shadow_unique;
   bit [3:0]      reg_num_funcs = 4'd4;
   bit [6:0]      reg_key_window = 7'd16;
   bit [20:0]     reg_modulus = 21'd1048573;

   bloom_rsp_type pending_results[$];
   int            error_count;
   bit            push_idle_on;
   bit            pop_idle_on;
   int            quiet_cycles;

   // Saved keys for replay lookups
   bit [7:0]      saved_keys [8][MAX_KEY_LEN];
   int            saved_len [8];
   int            saved_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Update the shadow for one accepted request and, for a last key byte, queue its result
   task automatic predict_request(bit is_key, bit [9:0] slot, bit [31:0] cval,
                                  bit [7:0] kbyte, bit last, bit set_mode);
      int unsigned   w, nf, m, pos, s, idx, missing;
      bloom_rsp_type r;
      if (!is_key) begin
         if (slot < COEF_SLOTS) shadow_coef[slot] = cval;
         return;
      end
      w = reg_key_window;
      if (w[0]) w++;
      if (w < 2) w = 2;
      if (w > MAX_KEY_WINDOW) w = MAX_KEY_WINDOW;
      shadow_byte_count++;
      pos = shadow_byte_count % w;
      for (int f = 0; f < MAX_FUNCS; f++) begin
         s = f * w + pos;
         if (s < COEF_SLOTS)
            shadow_acc[f] = shadow_acc[f] + 32'(kbyte) * shadow_coef[s];
      end
      if (!last) return;
      nf = reg_num_funcs;
      if (nf < 1) nf = 1;
      if (nf > MAX_FUNCS) nf = MAX_FUNCS;
      m = reg_modulus;
      if (m < 1) m = 1;
      if (m > STORE_BITS) m = STORE_BITS;
      missing = 0;
      // Probes are sequential: a repeated index sees an earlier set
      for (int f = 0; f < nf; f++) begin
         idx = shadow_acc[f] % m;
         if (!shadow_store[idx]) begin
            missing++;
            if (set_mode) shadow_store[idx] = 1'b1;
         end
      end
      if (set_mode && missing != 0) begin
         shadow_bits_total += missing;
         shadow_unique++;
      end
      for (int f = 0; f < MAX_FUNCS; f++) shadow_acc[f] = '0;
      shadow_byte_count = '0;
      r.missing_bits = 4'(missing);
      r.bits_set = 21'(shadow_bits_total);
      r.unique_count = shadow_unique;
      pending_results.push_back(r);
   endtask

   // Send one request, then, when push idling is on, hold off for a random gap
   task automatic send_request(bit is_key, bit [9:0] slot, bit [31:0] cval,
                               bit [7:0] kbyte, bit last, bit set_mode);
      int gap;
      req_push <= 1'b1;
      req_type <= is_key ? REQ_KEY : REQ_COEF;
      req_coef_index <= slot;
      req_coef_value <= cval;
      req_key_byte <= kbyte;
      req_last_byte <= last;
      req_do_set <= set_mode;
      do @(posedge clock); while (req_full);
      predict_request(is_key, slot, cval, kbyte, last, set_mode);
      gap = push_idle_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_key(bit [7:0] bytes [MAX_KEY_LEN], int len, bit set_mode);
      for (int i = 0; i < len; i++)
         send_request(1'b1, 10'($urandom), $urandom, bytes[i], i == len - 1,
                      (i == len - 1) ? set_mode : 1'($urandom));
   endtask

   // Wait until every result is back and the engine has drained
   task automatic settle();
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, bit [20:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_NUM_FUNCS:  reg_num_funcs = data[3:0];
         CSR_KEY_WINDOW: reg_key_window = data[6:0];
         CSR_MODULUS:    reg_modulus = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(bit [20:0] nf, bit [20:0] w, bit [20:0] m);
      settle();
      write_csr(CSR_NUM_FUNCS, nf);
      write_csr(CSR_KEY_WINDOW, w);
      write_csr(CSR_MODULUS, m);
   endtask

   // Every slot gets a value so no unwritten coefficient is ever read
   task automatic test_coef_load();
      for (int i = 0; i < COEF_SLOTS; i++)
         send_request(1'b0, 10'(i), $urandom, 8'($urandom), 1'($urandom),
                      1'($urandom));
      send_request(1'b0, 10'd0, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1);
      send_request(1'b0, 10'(COEF_SLOTS - 1), 32'h0, 8'h00, 1'b0, 1'b0);
      send_request(1'b0, 10'(COEF_SLOTS), 32'h1234_5678, 8'h00, 1'b0, 1'b0);
      send_request(1'b0, 10'h3FF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1);
   endtask

   task automatic test_directed_keys();
      bit [7:0] k [MAX_KEY_LEN];
      // zero byte: all indexes land on bit 0
      k[0] = 8'h00;
      send_key(k, 1, 1'b1);
      k[0] = 8'hFF;
      send_key(k, 1, 1'b1);
      // same key again, test only: should be present
      send_key(k, 1, 1'b0);
      k[0] = 8'h5A; k[1] = 8'hA5; k[2] = 8'h3C;
      send_key(k, 3, 1'b0);
      // key longer than the window wraps the byte position
      for (int i = 0; i < MAX_KEY_LEN; i++) k[i] = 8'($urandom);
      send_key(k, MAX_KEY_LEN, 1'b1);
      send_key(k, MAX_KEY_LEN, 1'b0);
   endtask

   // Out-of-range registers are clamped
   task automatic test_config_extremes();
      bit [7:0] k [MAX_KEY_LEN];
      for (int i = 0; i < MAX_KEY_LEN; i++) k[i] = 8'($urandom);
      set_config(21'hF, 21'd1, 21'd0);
      send_key(k, 5, 1'b1);
      set_config(21'h1FFFF0, 21'd127, 21'h1FFFFF);
      write_csr(CSR_SPARE, 21'h1FFFFF);
      send_key(k, 5, 1'b1);
      set_config(21'd9, 21'd64, 21'd1048576);
      send_key(k, 3, 1'b1);
      set_config(21'd1, 21'd2, 21'd1);
      send_key(k, 3, 1'b0);
   endtask

   // Register change between bytes of one key
   task automatic test_config_mid_key();
      set_config(21'd4, 21'd16, 21'd1048573);
      send_request(1'b1, 10'd0, 32'd0, 8'h77, 1'b0, 1'b0);
      send_request(1'b1, 10'd0, 32'd0, 8'h19, 1'b0, 1'b1);
      settle();
      write_csr(CSR_KEY_WINDOW, 21'd6);
      write_csr(CSR_NUM_FUNCS, 21'd7);
      send_request(1'b1, 10'd0, 32'd0, 8'hC3, 1'b1, 1'b1);
   endtask

   task automatic test_random(int phase, int item_goal);
      bit [7:0] k [MAX_KEY_LEN];
      int sent, len, pick;
      bit [20:0] m;
      case ($urandom_range(0, 2))
         0: m = 21'($urandom_range(1, 64));
         1: m = 21'd1048573;
         default: m = 21'($urandom);
      endcase
      set_config(21'($urandom), 21'($urandom), m);
      push_idle_on = (phase % 3) != 0;
      pop_idle_on = (phase % 2) != 0;
      sent = 0;
      while (sent < item_goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            // noise: coefficient reload, possibly to an ignored slot
            send_request(1'b0, 10'($urandom), $urandom, 8'($urandom), 1'($urandom),
                         1'($urandom));
            sent++;
         end else if (pick < 20 && saved_count > 0) begin
            pick = $urandom_range(0, (saved_count > 8 ? 8 : saved_count) - 1);
            send_key(saved_keys[pick], saved_len[pick], 1'($urandom_range(0, 3) == 0));
            sent += saved_len[pick];
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_KEY_LEN)
                                               : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) k[i] = 8'($urandom);
            send_key(k, len, 1'($urandom));
            saved_keys[saved_count % 8] = k;
            saved_len[saved_count % 8] = len;
            saved_count++;
            sent += len;
         end
      end
   endtask

   // Result side: random pop stalls, compare against the oldest expectation
   initial begin
      int stall;
      bloom_rsp_type e;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: missing_bits %0d", rsp_missing_bits);
               error_count++;
            end else begin
               e = pending_results.pop_front();
               if (rsp_missing_bits !== e.missing_bits) begin
                  $error("missing_bits expected %0d actual %0d", e.missing_bits,
                         rsp_missing_bits);
                  error_count++;
               end
               if (rsp_bits_set !== e.bits_set) begin
                  $error("bits_set expected %0d actual %0d", e.bits_set, rsp_bits_set);
                  error_count++;
               end
               if (rsp_unique_count !== e.unique_count) begin
                  $error("unique_count expected %0d actual %0d", e.unique_count,
                         rsp_unique_count);
                  error_count++;
               end
            end
            stall = pop_idle_on ? $urandom_range(0, 14) : 0;
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no handshake
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Test sequence
   initial begin
      error_count = 0;
      saved_count = 0;
      push_idle_on = 1'b1;
      pop_idle_on = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_coef_load();
      test_directed_keys();
      test_config_extremes();
      test_config_mid_key();
      for (int p = 0; p < 6; p++) test_random(p, 205);
      settle();
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

FILE: sim.f
sv/bft_pkg.sv
sv/bft_ram.sv
sv/bft_front.sv
sv/bft_divider.sv
sv/bft_engine.sv
sv/bloom_filter_test_or_set.sv
verif/testbench.sv
